### rtl/assert_macros.svh
// Assertion macros, included by two_stack_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_HOLD(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### rtl/tsq_pkg.sv
// Types and constants of the two-stack queue.
package tsq_pkg;

    localparam int DEF_MAX_DEPTH  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CAP_W   = 5;
    localparam int REQ_W   = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FRONT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [STAT_W-1:0]         status;
    } t_rsp;

endpackage

### rtl/tsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
    parameter int WIDTH = tsq_pkg::DEF_DATA_WIDTH,
    parameter int DEPTH = tsq_pkg::DEF_MAX_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/two_stack_queue.sv
// Two-stack FIFO queue: top level with sequencer and both stack memories.
//
//  channel  | strobe / accept          | payload
//  ---------+--------------------------+----------------------------
//  request  | start & !busy            | i_req  (tsq_pkg::t_req)
//  result   | o_done, one cycle        | o_rsp  (tsq_pkg::t_rsp)
//  config   | i_cfg_we                 | i_cfg_wdata (stack capacity)
//
// Enqueue, empty read and unused codes: result in the cycle after accept, busy stays low.
// Dequeue/front with the output stack loaded: the result is registered in S_RESP.
// With the output stack empty, n input entries move one per cycle through the
// input stack's read port in S_XFER, n at most MAX_DEPTH; then S_RESP registers the result.
// Reset is synchronous, active low; both stacks come up empty, capacity 16.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "assert_macros.svh"

module two_stack_queue #(
    parameter int MAX_DEPTH  = tsq_pkg::DEF_MAX_DEPTH,
    parameter int DATA_WIDTH = tsq_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  tsq_pkg::t_req                i_req,
    output logic                         busy,
    output logic                         o_done,
    output tsq_pkg::t_rsp                o_rsp,
    input  logic                         i_cfg_we,
    input  logic [tsq_pkg::CAP_W-1:0]    i_cfg_wdata
);

    localparam int CW   = $clog2(MAX_DEPTH + 1);
    localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMPW = (CW > tsq_pkg::CAP_W) ? CW : tsq_pkg::CAP_W;

    typedef enum logic [1:0] {S_IDLE, S_XFER, S_RESP} t_state;

    t_state                    r_state;
    logic [CW-1:0]             r_in_cnt;
    logic [CW-1:0]             r_out_cnt;
    logic                      r_pend;
    logic                      r_deq;
    logic [tsq_pkg::CAP_W-1:0] r_cap;
    logic                      r_done;
    tsq_pkg::t_rsp             r_rsp;

    logic                      accept;
    logic                      overflow;
    logic [tsq_pkg::CAP_W-1:0] eff_cap;
    logic [CW-1:0]             in_cnt_m1;
    logic [CW-1:0]             out_cnt_m1;
    logic                      in_we;
    logic                      out_we;
    logic                      in_xfer;
    logic                      quick_req;
    logic                      xfer_ok;
    logic [DATA_WIDTH-1:0]     push_data;
    logic [DATA_WIDTH-1:0]     in_rdata;
    logic [DATA_WIDTH-1:0]     out_rdata;
    logic [tsq_pkg::VALUE_W-1:0] top_value;

    assign accept     = start && !busy;
    assign eff_cap    = (r_cap == '0) ? tsq_pkg::CAP_W'(1) : r_cap;
    assign overflow   = (r_in_cnt == CW'(MAX_DEPTH)) || (CMPW'(r_in_cnt) >= CMPW'(eff_cap));
    assign in_cnt_m1  = r_in_cnt - CW'(1);
    assign out_cnt_m1 = r_out_cnt - CW'(1);
    assign push_data  = DATA_WIDTH'($unsigned(i_req.push_value));
    assign top_value  = tsq_pkg::VALUE_W'(out_rdata);

    assign in_xfer   = (r_state == S_XFER);
    assign quick_req = accept && (i_req.req_type != tsq_pkg::REQ_DEQ)
                       && (i_req.req_type != tsq_pkg::REQ_FRONT);
    assign xfer_ok   = (r_out_cnt == '0) && (r_in_cnt != '0);

    assign in_we  = accept && (i_req.req_type == tsq_pkg::REQ_ENQ) && !overflow;
    assign out_we = in_xfer && r_pend;

    tsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_in_stack (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_in_cnt[AW-1:0]),
        .i_wdata (push_data),
        .i_raddr (in_cnt_m1[AW-1:0]),
        .o_rdata (in_rdata)
    );

    tsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_out_stack (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (r_out_cnt[AW-1:0]),
        .i_wdata (in_rdata),
        .i_raddr (out_cnt_m1[AW-1:0]),
        .o_rdata (out_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_pend    <= 1'b0;
            r_deq     <= 1'b0;
            r_cap     <= tsq_pkg::CAP_RESET;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req.req_type)
                            tsq_pkg::REQ_ENQ: begin
                                r_done           <= 1'b1;
                                r_rsp.read_value <= '0;
                                if (overflow) begin
                                    r_rsp.status <= tsq_pkg::ST_OVERFLOW;
                                end else begin
                                    r_rsp.status <= tsq_pkg::ST_OK;
                                    r_in_cnt     <= r_in_cnt + CW'(1);
                                end
                            end
                            tsq_pkg::REQ_DEQ, tsq_pkg::REQ_FRONT: begin
                                r_deq <= (i_req.req_type == tsq_pkg::REQ_DEQ);
                                if (r_in_cnt == '0 && r_out_cnt == '0) begin
                                    r_done           <= 1'b1;
                                    r_rsp.read_value <= '1;
                                    r_rsp.status     <= tsq_pkg::ST_EMPTY;
                                end else if (r_out_cnt == '0) begin
                                    r_pend  <= 1'b0;
                                    r_state <= S_XFER;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            default: begin
                                r_done           <= 1'b1;
                                r_rsp.read_value <= '0;
                                r_rsp.status     <= tsq_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_XFER: begin
                    // pop one entry per cycle, push it in the next cycle
                    if (r_in_cnt != '0) begin
                        r_in_cnt <= in_cnt_m1;
                        r_pend   <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_out_cnt <= r_out_cnt + CW'(1);
                    end
                    // last push landed last cycle: top read is under way now
                    if (r_in_cnt == '0 && !r_pend) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_done           <= 1'b1;
                    r_rsp.read_value <= top_value;
                    r_rsp.status     <= tsq_pkg::ST_OK;
                    if (r_deq) begin
                        r_out_cnt <= out_cnt_m1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `ASSERT_NEVER(a_done_while_busy, i_clk, i_rst_n, o_done && busy, "result strobe while busy")
    `ASSERT_NEVER(a_in_cnt_range, i_clk, i_rst_n, r_in_cnt > CW'(MAX_DEPTH), "input count above depth")
    `ASSERT_NEVER(a_out_cnt_range, i_clk, i_rst_n, r_out_cnt > CW'(MAX_DEPTH), "output count too high")
    `ASSERT_HOLD(a_quick_result, i_clk, i_rst_n, quick_req |=> o_done, "no quick result")
    `ASSERT_HOLD(a_xfer_only_empty, i_clk, i_rst_n, $rose(in_xfer) |-> xfer_ok, "bad transfer")

endmodule

### tb/tb_two_stack_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-stack queue: directed and random requests.
module tb_two_stack_queue;

    localparam logic [tsq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int QDEPTH       = tsq_pkg::DEF_MAX_DEPTH;
    localparam int SETTLE       = tsq_pkg::DEF_MAX_DEPTH + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 115;
    localparam int NUM_PHASES   = 7;

    class queue_tracker;
        logic signed [tsq_pkg::VALUE_W-1:0] in_stack[QDEPTH];
        logic signed [tsq_pkg::VALUE_W-1:0] out_stack[QDEPTH];
        int unsigned in_fill;
        int unsigned out_fill;
        logic [tsq_pkg::CAP_W-1:0] cap_reg;
        tsq_pkg::t_rsp expected_rsp[$];
        int unsigned mismatches;

        function new();
            in_fill    = 0;
            out_fill   = 0;
            cap_reg    = tsq_pkg::CAP_RESET;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_rsp.size();
        endfunction

        function void note_request(tsq_pkg::t_req r);
            tsq_pkg::t_rsp rsp;
            int unsigned limit;
            rsp.read_value = '0;
            rsp.status     = tsq_pkg::ST_OK;
            limit = 32'(cap_reg);
            if (limit < 1) limit = 1;
            if (limit > QDEPTH) limit = QDEPTH;
            case (r.req_type)
                tsq_pkg::REQ_ENQ: begin
                    if (in_fill >= limit) begin
                        rsp.status = tsq_pkg::ST_OVERFLOW;
                    end else begin
                        in_stack[in_fill] = r.push_value;
                        in_fill++;
                    end
                end
                tsq_pkg::REQ_DEQ, tsq_pkg::REQ_FRONT: begin
                    if (in_fill == 0 && out_fill == 0) begin
                        rsp.read_value = -1;
                        rsp.status     = tsq_pkg::ST_EMPTY;
                    end else begin
                        // refill reverses order, oldest ends on top
                        if (out_fill == 0) begin
                            while (in_fill > 0) begin
                                in_fill--;
                                out_stack[out_fill] = in_stack[in_fill];
                                out_fill++;
                            end
                        end
                        rsp.read_value = out_stack[out_fill-1];
                        if (r.req_type == tsq_pkg::REQ_DEQ) out_fill--;
                    end
                end
                default: ;
            endcase
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(tsq_pkg::t_rsp got);
            tsq_pkg::t_rsp want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value %0d status %0d",
                         $time, got.read_value, got.status);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %0d actual %0d",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    tsq_pkg::t_req             i_req       = '0;
    logic                      busy;
    logic                      o_done;
    tsq_pkg::t_rsp             o_rsp;
    logic                      i_cfg_we    = 1'b0;
    logic [tsq_pkg::CAP_W-1:0] i_cfg_wdata = tsq_pkg::CAP_RESET;

    queue_tracker tracker = new();
    int unsigned  cycle_count = 0;

    two_stack_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // check before noting, so a result never matches an item of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) tracker.check_response(o_rsp);
            if (start && !busy) tracker.note_request(i_req);
        end
    end

    function automatic tsq_pkg::t_req make_req(logic [tsq_pkg::REQ_W-1:0] kind,
                                               logic [tsq_pkg::VALUE_W-1:0] value);
        tsq_pkg::t_req r;
        r.req_type   = kind;
        r.push_value = value;
        return r;
    endfunction

    function automatic tsq_pkg::t_req random_req(int unsigned enq_pct);
        tsq_pkg::t_req r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
            r.req_type = REQ_UNUSED;
        else if (pick < enq_pct)
            r.req_type = tsq_pkg::REQ_ENQ;
        else if ($urandom_range(2) == 0)
            r.req_type = tsq_pkg::REQ_FRONT;
        else
            r.req_type = tsq_pkg::REQ_DEQ;
        case ($urandom_range(9))
            0: r.push_value = 32'h7FFF_FFFF;
            1: r.push_value = 32'h8000_0000;
            2: r.push_value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: r.push_value = $urandom;
        endcase
        return r;
    endfunction

    // hold the item until the block takes it
    task automatic send_item(tsq_pkg::t_req r, int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // write only with no result outstanding
    task automatic write_capacity(logic [tsq_pkg::CAP_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.cap_reg = value;
    endtask

    initial begin
        int unsigned idle_pct;
        int unsigned seg_idle;
        int unsigned enq_pct;
        logic [tsq_pkg::CAP_W-1:0] cap;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty reads, unused code, extreme values, refill order
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_FRONT, 32'h0), 0);
        send_item(make_req(REQ_UNUSED, 32'h1234_5678), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'h7FFF_FFFF), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'h8000_0000), 0);
        send_item(make_req(tsq_pkg::REQ_FRONT, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);

        // smallest capacity, then zero acting as one
        write_capacity(5'd1);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'hFFFF_FFFF), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'hAAAA_AAAA), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        write_capacity(5'd0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'h5555_5555), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'h0000_0001), 0);
        send_item(make_req(tsq_pkg::REQ_FRONT, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);

        // lower capacity below the current fill
        write_capacity(5'd16);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'd11), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'd22), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'd33), 0);
        write_capacity(5'd2);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'd44), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_ENQ, 32'd55), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);
        send_item(make_req(tsq_pkg::REQ_DEQ, 32'h0), 0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin cap = 5'd16; idle_pct = 0;  end
                1: begin cap = 5'd5;  idle_pct = 51; end
                2: begin cap = 5'd31; idle_pct = 37; end
                3: begin cap = 5'd1;  idle_pct = 0;  end
                4: begin cap = 5'd0;  idle_pct = 51; end
                5: begin cap = 5'($urandom_range(31)); idle_pct = 37; end
                default: begin cap = 5'd16; idle_pct = 51; end
            endcase
            write_capacity(cap);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // pick fill-heavy, balanced or drain-heavy stretches at random
                if (n % 16 == 0) begin
                    case ($urandom_range(2))
                        0: enq_pct = 20;
                        1: enq_pct = 50;
                        default: enq_pct = 85;
                    endcase
                    seg_idle = ($urandom_range(3) == 0) ? 0 : idle_pct;
                end
                send_item(random_req(enq_pct), seg_idle);
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tsq_pkg.sv
rtl/tsq_ram.sv
rtl/two_stack_queue.sv
tb/tb_two_stack_queue.sv
